// ===== design/m4i_pkg.sv =====
`timescale 1ns / 1ps

package m4i_pkg;

    // Digit width of the shared serial multiplier.
    localparam int DIGIT_BITS = 8;

    // Slot of the final result of a run.
    localparam logic [3:0] LAST_SLOT = 4'd15;

    // Last group of the sub-determinant and cofactor phases, and the sub-determinants per row pair.
    localparam logic [3:0] SUB_LAST = 4'd11;
    localparam logic [3:0] COF_LAST = 4'd15;
    localparam logic [3:0] SUB_HALF = 4'd6;

    typedef enum logic [1:0] {
        A_ELEM = 2'd0,
        A_SUB  = 2'd1,
        A_COF  = 2'd2
    } a_sel_t;

    typedef enum logic [1:0] {
        D_SUB = 2'd0,
        D_COF = 2'd1,
        D_DET = 2'd2
    } dest_t;

    typedef enum logic [1:0] {
        PH_SUB = 2'd0,
        PH_COF = 2'd1,
        PH_DET = 2'd2
    } phase_t;

    // One multiply-accumulate step of the inversion.
    typedef struct packed {
        a_sel_t     a_sel;
        logic [3:0] a_idx;
        logic [3:0] e_idx;
        logic       neg;
        logic       first;
        logic       wr;
        dest_t      dest;
        logic [3:0] dest_idx;
    } mul_cmd_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       mul_start;
        mul_cmd_t   mul;
        logic       div_start;
        logic       out_load;
        logic [3:0] idx;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_busy;
        logic div_busy;
        logic out_free;
    } dp_status_t;

    // Index of a column pair (a < b) in the sub-determinant store.
    function automatic logic [2:0] pair_idx(logic [1:0] a, logic [1:0] b);
        logic [2:0] r;
        case (a)
            2'd0:    r = {1'b0, b} - 3'd1;
            2'd1:    r = {1'b0, b} + 3'd1;
            default: r = 3'd5;
        endcase
        return r;
    endfunction

    // Multiply step for a phase, a group and a term within the group.
    function automatic mul_cmd_t mul_cmd(phase_t ph, logic [3:0] grp, logic [1:0] term);
        mul_cmd_t   c;
        logic       rp;
        logic [2:0] p;
        logic [1:0] c0, c1, r0, r1;
        logic [1:0] i, j, k, cc0, cc1, cc2, cck, ox, oy, er;
        logic [3:0] base;
        c    = '0;
        rp   = (grp >= SUB_HALF);
        p    = rp ? 3'(grp - SUB_HALF) : grp[2:0];
        case (p)
            3'd0:    begin c0 = 2'd0; c1 = 2'd1; end
            3'd1:    begin c0 = 2'd0; c1 = 2'd2; end
            3'd2:    begin c0 = 2'd0; c1 = 2'd3; end
            3'd3:    begin c0 = 2'd1; c1 = 2'd2; end
            3'd4:    begin c0 = 2'd1; c1 = 2'd3; end
            default: begin c0 = 2'd2; c1 = 2'd3; end
        endcase
        r0   = rp ? 2'd0 : 2'd2;
        r1   = {r0[1], 1'b1};
        i    = grp[3:2];
        j    = grp[1:0];
        k    = term;
        cc0  = (2'd0 < j) ? 2'd0 : 2'd1;
        cc1  = (2'd1 < j) ? 2'd1 : 2'd2;
        cc2  = (2'd2 < j) ? 2'd2 : 2'd3;
        case (k)
            2'd0:    begin cck = cc0; ox = cc1; oy = cc2; end
            2'd1:    begin cck = cc1; ox = cc0; oy = cc2; end
            default: begin cck = cc2; ox = cc0; oy = cc1; end
        endcase
        // Cofactors of rows 0 and 1 expand over rows 2 and 3, and the other way round.
        er   = i ^ 2'd1;
        base = i[1] ? SUB_HALF : 4'd0;
        case (ph)
            PH_SUB: begin
                c.a_sel    = A_ELEM;
                c.dest     = D_SUB;
                c.dest_idx = grp;
                if (term[0] == 1'b0) begin
                    c.a_idx = {c0, r0};
                    c.e_idx = {c1, r1};
                    c.first = 1'b1;
                end else begin
                    c.a_idx = {c1, r0};
                    c.e_idx = {c0, r1};
                    c.neg   = 1'b1;
                    c.wr    = 1'b1;
                end
            end
            PH_COF: begin
                c.a_sel    = A_SUB;
                c.a_idx    = base + {1'b0, pair_idx(ox, oy)};
                c.e_idx    = {cck, er};
                c.neg      = i[0] ^ j[0] ^ k[0];
                c.first    = (k == 2'd0);
                c.wr       = (k == 2'd2);
                c.dest     = D_COF;
                c.dest_idx = grp;
            end
            default: begin
                c.a_sel    = A_COF;
                c.a_idx    = {2'b00, term};
                c.e_idx    = {term, 2'b00};
                c.first    = (term == 2'd0);
                c.wr       = (term == 2'd3);
                c.dest     = D_DET;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== design/matrix4_inverse.sv =====
`timescale 1ns / 1ps

// 4x4 matrix inverse by cofactors, signed fixed point (Q16.16 by default).
// Input channel (s_valid/s_ready): each transaction stores one element at slot
// column*4 + row. A transaction with s_compute set stores its element and then
// inverts the stored matrix. Loads can follow back to back while the block is idle.
// Output channel (m_valid/m_ready): sixteen transactions per inversion, slots 0
// to 15 in order, m_last on slot 15, m_singular on all of them when the
// determinant is zero (values are then zero). Results saturate.
// The inversion runs 76 multiply steps on one shared digit-serial multiplier, then
// one restoring division per result; each step and each division finishes before
// the next one starts.
// The block takes no new input until the last result has been registered.
// Reset clears the control state; the matrix store holds garbage until written.
// If the receiver stalls, the current result holds in the output register and
// the next quotient waits in the divider until the register frees up.
module matrix4_inverse #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_WIDTH-1:0] s_element_value,
    input  logic [3:0]                    s_element_index,
    input  logic                          s_compute,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [VALUE_WIDTH-1:0] m_result_value,
    output logic [3:0]                    m_result_index,
    output logic                          m_singular,
    output logic                          m_last
);

    m4i_pkg::dp_cmd_t    cmd;
    m4i_pkg::dp_status_t status;

    // Sequencer.
    m4i_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_compute (s_compute),
        .s_ready   (s_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Stores, multiplier, divider and output register.
    m4i_dpath #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_element_value (s_element_value),
        .s_element_index (s_element_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .m_result_index  (m_result_index),
        .m_singular      (m_singular),
        .m_last          (m_last)
    );

endmodule

// ===== design/m4i_ctrl.sv =====
`timescale 1ns / 1ps

module m4i_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_compute,
    output logic                  s_ready,
    input  m4i_pkg::dp_status_t   status,
    output m4i_pkg::dp_cmd_t      cmd
);

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_MUL_ISSUE = 5'b00010,
        ST_MUL_WAIT  = 5'b00100,
        ST_DIV_ISSUE = 5'b01000,
        ST_DIV_WAIT  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    m4i_pkg::phase_t   phase_reg, phase_next;
    logic [3:0]        grp_reg, grp_next;
    logic [1:0]        term_reg, term_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Sequencing of element loads, multiply steps, divisions and result transactions.
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        grp_next   = grp_reg;
        term_next  = term_reg;
        cmd        = '0;
        cmd.idx    = grp_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_compute) begin
                        state_next = ST_MUL_ISSUE;
                        phase_next = m4i_pkg::PH_SUB;
                        grp_next   = '0;
                        term_next  = '0;
                    end
                end
            end
            ST_MUL_ISSUE: begin
                cmd.mul_start = 1'b1;
                cmd.mul       = m4i_pkg::mul_cmd(phase_reg, grp_reg, term_reg);
                state_next    = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (!status.mul_busy) begin
                    state_next = ST_MUL_ISSUE;
                    case (phase_reg)
                        m4i_pkg::PH_SUB: begin
                            if (term_reg == 2'd1) begin
                                term_next = '0;
                                if (grp_reg == m4i_pkg::SUB_LAST) begin
                                    phase_next = m4i_pkg::PH_COF;
                                    grp_next   = '0;
                                end else begin
                                    grp_next = grp_reg + 4'd1;
                                end
                            end else begin
                                term_next = term_reg + 2'd1;
                            end
                        end
                        m4i_pkg::PH_COF: begin
                            if (term_reg == 2'd2) begin
                                term_next = '0;
                                if (grp_reg == m4i_pkg::COF_LAST) begin
                                    phase_next = m4i_pkg::PH_DET;
                                    grp_next   = '0;
                                end else begin
                                    grp_next = grp_reg + 4'd1;
                                end
                            end else begin
                                term_next = term_reg + 2'd1;
                            end
                        end
                        default: begin
                            if (term_reg == 2'd3) begin
                                state_next = ST_DIV_ISSUE;
                                grp_next   = '0;
                                term_next  = '0;
                            end else begin
                                term_next = term_reg + 2'd1;
                            end
                        end
                    endcase
                end
            end
            ST_DIV_ISSUE: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!status.div_busy && status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (grp_reg == m4i_pkg::LAST_SLOT) begin
                        state_next = ST_IDLE;
                    end else begin
                        grp_next   = grp_reg + 4'd1;
                        state_next = ST_DIV_ISSUE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Controller registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= m4i_pkg::PH_SUB;
            grp_reg   <= '0;
            term_reg  <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            grp_reg   <= grp_next;
            term_reg  <= term_next;
        end
    end

endmodule

// ===== design/m4i_dpath.sv =====
`timescale 1ns / 1ps

module m4i_dpath #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  m4i_pkg::dp_cmd_t              cmd,
    output m4i_pkg::dp_status_t           status,
    input  logic signed [VALUE_WIDTH-1:0] s_element_value,
    input  logic [3:0]                    s_element_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [VALUE_WIDTH-1:0] m_result_value,
    output logic [3:0]                    m_result_index,
    output logic                          m_singular,
    output logic                          m_last
);

    localparam int W    = VALUE_WIDTH;
    localparam int DB   = m4i_pkg::DIGIT_BITS;
    localparam int DW   = (W + DB - 1) / DB;
    localparam int EW   = DW * DB;
    localparam int SBW  = 2 * W + 1;
    localparam int CFW  = 3 * W + 3;
    localparam int AW   = CFW;
    localparam int SW   = 4 * W + 5;
    localparam int PW   = AW + EW;
    localparam int DVW  = 5 * W + 2 * FRACTION_BITS + 8;
    localparam int MCW  = $clog2(DW);
    localparam int QCW  = $clog2(W);

    // Local stores: matrix, 2x2 sub-determinants, signed cofactors, determinant.
    logic signed [W-1:0]   mat_reg [16];
    logic signed [SBW-1:0] sub_reg [12];
    logic signed [CFW-1:0] cof_reg [16];
    logic signed [SW-1:0]  det_reg;
    logic signed [SW-1:0]  sum_reg;

    // Serial multiplier state.
    logic                  mbusy_reg;
    logic [MCW-1:0]        mcnt_reg;
    logic                  mtop_reg;
    logic signed [AW-1:0]  a_reg;
    logic [EW-1:0]         e_reg;
    logic signed [PW-1:0]  prod_reg;
    logic                  mneg_reg, mfirst_reg, mwr_reg;
    m4i_pkg::dest_t        mdest_reg;
    logic [3:0]            midx_reg;

    // Divider state.
    logic                  dbusy_reg;
    logic [QCW-1:0]        dcnt_reg;
    logic [DVW-1:0]        rem_reg, dsh_reg;
    logic [W-1:0]          q_reg;
    logic                  dneg_reg, sat_reg;
    logic signed [W-1:0]   dres_reg;

    // Output register.
    logic                  m_valid_reg;
    logic signed [W-1:0]   m_value_reg;
    logic [3:0]            m_index_reg;
    logic                  m_singular_reg, m_last_reg;

    logic signed [AW-1:0]     a_load;
    logic [EW-1:0]            e_load;
    logic [DB-1:0]            digit;
    logic signed [DB:0]       dsig;
    logic signed [AW+DB:0]    pp;
    logic signed [PW-1:0]     prod_next;
    logic signed [SW-1:0]     prod_sw, sum_next;
    logic signed [CFW-1:0]    num_v;
    logic [CFW-1:0]           num_abs;
    logic [SW-1:0]            den_abs;
    logic [DVW-1:0]           n_init, dsh_init, rem_sub;
    logic                     ge, det_zero, sat_fin;
    logic [W-1:0]             q_next;
    logic signed [W-1:0]      dres_next;

    assign det_zero = (det_reg == '0);

    // Multiplier operand selection at the start of a step.
    always_comb begin
        case (cmd.mul.a_sel)
            m4i_pkg::A_ELEM: a_load = AW'(mat_reg[cmd.mul.a_idx]);
            m4i_pkg::A_SUB:  a_load = AW'(sub_reg[cmd.mul.a_idx]);
            default:         a_load = AW'(cof_reg[cmd.mul.a_idx]);
        endcase
        e_load = EW'(mat_reg[cmd.mul.e_idx]);
    end

    // One digit per cycle, top digit first and signed, the rest unsigned.
    always_comb begin
        digit     = e_reg[EW-1 -: DB];
        dsig      = $signed({mtop_reg & digit[DB-1], digit});
        pp        = a_reg * dsig;
        prod_next = (prod_reg <<< DB) + PW'(pp);
        prod_sw   = SW'(prod_next);
        sum_next  = (mfirst_reg ? SW'(0) : sum_reg) + (mneg_reg ? -prod_sw : prod_sw);
    end

    // Divider setup: magnitudes, scaled numerator plus half divisor for rounding.
    always_comb begin
        num_v    = cof_reg[cmd.idx];
        num_abs  = num_v[CFW-1] ? CFW'(-num_v) : CFW'(num_v);
        den_abs  = det_reg[SW-1] ? SW'(-det_reg) : SW'(det_reg);
        n_init   = (DVW'(num_abs) << (2 * FRACTION_BITS + 1)) + DVW'(den_abs);
        dsh_init = DVW'(den_abs) << W;
    end

    // Restoring division step; the first step detects saturation.
    always_comb begin
        ge      = (rem_reg >= dsh_reg);
        rem_sub = rem_reg - dsh_reg;
        q_next  = {q_reg[W-2:0], ge};
        sat_fin = (dcnt_reg == QCW'(W - 1)) ? ge : sat_reg;
        if (sat_fin) begin
            dres_next = dneg_reg ? $signed({1'b1, {(W-1){1'b0}}})
                                 : $signed({1'b0, {(W-1){1'b1}}});
        end else begin
            dres_next = dneg_reg ? -$signed(q_next) : $signed(q_next);
        end
    end

    // Stores and payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mat_reg[s_element_index] <= s_element_value;
        end
        if (cmd.mul_start) begin
            a_reg      <= a_load;
            e_reg      <= e_load;
            prod_reg   <= '0;
            mcnt_reg   <= MCW'(DW - 1);
            mtop_reg   <= 1'b1;
            mneg_reg   <= cmd.mul.neg;
            mfirst_reg <= cmd.mul.first;
            mwr_reg    <= cmd.mul.wr;
            mdest_reg  <= cmd.mul.dest;
            midx_reg   <= cmd.mul.dest_idx;
        end else if (mbusy_reg) begin
            prod_reg <= prod_next;
            e_reg    <= e_reg << DB;
            mtop_reg <= 1'b0;
            mcnt_reg <= mcnt_reg - MCW'(1);
            if (mcnt_reg == '0) begin
                sum_reg <= sum_next;
                if (mwr_reg) begin
                    case (mdest_reg)
                        m4i_pkg::D_SUB: sub_reg[midx_reg] <= sum_next[SBW-1:0];
                        m4i_pkg::D_COF: cof_reg[midx_reg] <= sum_next[CFW-1:0];
                        default:        det_reg <= sum_next;
                    endcase
                end
            end
        end
        if (cmd.div_start) begin
            rem_reg  <= n_init;
            dsh_reg  <= dsh_init;
            q_reg    <= '0;
            dcnt_reg <= QCW'(W - 1);
            sat_reg  <= 1'b0;
            dneg_reg <= num_v[CFW-1] ^ det_reg[SW-1];
            if (det_zero) begin
                dres_reg <= '0;
            end
        end else if (dbusy_reg) begin
            if (ge) begin
                rem_reg <= rem_sub;
            end
            dsh_reg  <= dsh_reg >> 1;
            q_reg    <= q_next;
            sat_reg  <= sat_fin;
            dcnt_reg <= dcnt_reg - QCW'(1);
            if (dcnt_reg == '0) begin
                dres_reg <= dres_next;
            end
        end
        if (cmd.out_load) begin
            m_value_reg    <= dres_reg;
            m_index_reg    <= cmd.idx;
            m_singular_reg <= det_zero;
            m_last_reg     <= (cmd.idx == m4i_pkg::LAST_SLOT);
        end
    end

    // Control flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbusy_reg   <= 1'b0;
            dbusy_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.mul_start) begin
                mbusy_reg <= 1'b1;
            end else if (mbusy_reg && mcnt_reg == '0) begin
                mbusy_reg <= 1'b0;
            end
            if (cmd.div_start) begin
                dbusy_reg <= !det_zero;
            end else if (dbusy_reg && dcnt_reg == '0) begin
                dbusy_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.mul_busy = mbusy_reg;
    assign status.div_busy = dbusy_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_value_reg;
    assign m_result_index = m_index_reg;
    assign m_singular     = m_singular_reg;
    assign m_last         = m_last_reg;

endmodule
